### hw/rtl/dfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants for the delimited fragment scanner.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int LEN_BITS    = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  MAX_DEPTH = 8'd255;
    localparam logic [15:0] LEN_LIMIT = 16'hFFFF;
    localparam logic [15:0] LEN_ONE   = 16'd1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_STR   = 3'd1,
        MODE_EXPR  = 3'd2,
        MODE_LINE  = 3'd3,
        MODE_BLOCK = 3'd4,
        MODE_SLASH = 3'd5
    } scan_mode_t;

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_STR     = 3'd1,
        KIND_EXPR    = 3'd2,
        KIND_LINE    = 3'd3,
        KIND_BLOCK   = 3'd4
    } frag_kind_t;

    // one classified byte, as it travels from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       start;
        logic       last;
        logic       is_quote;
        logic       is_open;
        logic [7:0] closer;
        logic       is_bslash;
        logic       is_slash;
        logic       is_star;
        logic       is_eol;
    } dfs_item_t;

endpackage

### hw/rtl/dfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_front
// Input handshake and byte classification; pushes classified items to the queue.
// ----------------------------------------------------------------------------
module dfs_front
    import dfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       start_req,
    input  logic       last,
    input  logic       q_full,
    output logic       push,
    output dfs_item_t  push_item
);

    logic       accept_seen_reg;
    logic       accept_seen_next;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.ch        = ch;
        push_item.start     = start_req;
        push_item.last      = last;
        push_item.is_quote  = (ch == CH_DQUOTE) || (ch == CH_SQUOTE) || (ch == CH_BTICK);
        push_item.is_open   = (ch == CH_LBRACE) || (ch == CH_LPAREN) || (ch == CH_LBRACK);
        push_item.is_bslash = (ch == CH_BSLASH);
        push_item.is_slash  = (ch == CH_SLASH);
        push_item.is_star   = (ch == CH_STAR);
        push_item.is_eol    = (ch == CH_LF) || (ch == CH_CR);
        case (ch)
            CH_LBRACE: push_item.closer = CH_RBRACE;
            CH_LPAREN: push_item.closer = CH_RPAREN;
            CH_LBRACK: push_item.closer = CH_RBRACK;
            default:   push_item.closer = CH_NUL;
        endcase
    end

    // tracks whether any item has been taken since reset (status for checks)
    assign accept_seen_next = accept_seen_reg || push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_seen_reg <= 1'b0;
        end
        else
        begin
            accept_seen_reg <= accept_seen_next;
        end
    end

`ifndef SYNTH
    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (in_valid && !q_full && accept_seen_next))
        else $error("front pushed without room");
`endif

endmodule

### hw/rtl/dfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_queue
// Short FIFO of classified items between the front and the scanner.
// ----------------------------------------------------------------------------
module dfs_queue
    import dfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  dfs_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output dfs_item_t q_item
);

    localparam logic [QUEUE_AW:0] COUNT_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    dfs_item_t            store_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;
    logic                 do_pop;

    assign full    = (count_reg == COUNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_item  = store_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
`endif

endmodule

### hw/rtl/dfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_back
// Fragment scanner: steps one queued item per cycle unless a held result is stalled, holds result register.
// ----------------------------------------------------------------------------
module dfs_back
    import dfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  dfs_item_t   q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] frag_len,
    output logic [2:0]  kind,
    output logic        unterminated,
    output logic        depth_overflow
);

    scan_mode_t  mode_reg, mode_next;
    logic [7:0]  close_reg, close_next;
    logic [7:0]  open_reg, open_next;
    logic [7:0]  depth_reg, depth_next;
    logic [7:0]  iquote_reg, iquote_next;
    logic        esc_reg, esc_next;
    logic        star_reg, star_next;
    logic [15:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;

    logic        out_valid_reg;
    logic [15:0] out_len_reg;
    frag_kind_t  out_kind_reg;
    logic        out_unterm_reg;
    logic        out_ovf_reg;

    logic        step;
    logic [15:0] cnt_inc;
    logic        in_quote;
    logic        hit_close;
    logic        hit_open;
    logic        ovf_upd;
    logic        hit;

    logic        res_emit;
    logic [15:0] res_len;
    frag_kind_t  res_kind;
    logic        res_unterm;
    logic        res_ovf;

    assign step  = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = step;

    assign cnt_inc   = (count_reg < LEN_LIMIT) ? count_reg + 16'd1 : count_reg;
    assign in_quote  = (iquote_reg != CH_NUL);
    assign hit_close = (q_item.ch == close_reg);
    assign hit_open  = (q_item.ch == open_reg);
    // closer has priority over opener inside an expression
    assign ovf_upd   = ovf_reg || (!in_quote && !hit_close && hit_open
                                   && (depth_reg == MAX_DEPTH));

    // closer reached on this byte, per mode
    always_comb
    begin
        case (mode_reg)
            MODE_STR:   hit = !esc_reg && !q_item.is_bslash && hit_close;
            MODE_EXPR:  hit = !in_quote && hit_close && (depth_reg == 8'd0);
            MODE_LINE:  hit = q_item.is_eol;
            MODE_BLOCK: hit = star_reg && q_item.is_slash;
            default:    hit = 1'b0;
        endcase
    end

    // result outputs
    always_comb
    begin
        res_emit   = 1'b0;
        res_len    = 16'd0;
        res_kind   = KIND_UNKNOWN;
        res_unterm = 1'b0;
        res_ovf    = 1'b0;
        unique case (mode_reg)
            MODE_STR:
            begin
                res_emit   = hit || q_item.last;
                res_len    = cnt_inc;
                res_kind   = KIND_STR;
                res_unterm = !hit;
            end
            MODE_EXPR:
            begin
                res_emit   = hit || q_item.last;
                res_len    = cnt_inc;
                res_kind   = KIND_EXPR;
                res_unterm = !hit;
                res_ovf    = ovf_upd;
            end
            MODE_LINE:
            begin
                res_emit   = hit || q_item.last;
                res_len    = cnt_inc;
                res_kind   = KIND_LINE;
                res_unterm = !hit;
            end
            MODE_BLOCK:
            begin
                res_emit   = hit || q_item.last;
                res_len    = cnt_inc;
                res_kind   = KIND_BLOCK;
                res_unterm = !hit;
            end
            MODE_SLASH:
            begin
                if (q_item.is_slash || q_item.is_star)
                begin
                    res_emit   = q_item.last;
                    res_len    = cnt_inc;
                    res_kind   = q_item.is_slash ? KIND_LINE : KIND_BLOCK;
                    res_unterm = 1'b1;
                end
                else
                begin
                    res_emit = 1'b1;
                end
            end
            default:
            begin
                // idle: only a flagged byte matters
                if (q_item.start)
                begin
                    if (q_item.is_quote || q_item.is_open)
                    begin
                        res_emit   = q_item.last;
                        res_len    = LEN_ONE;
                        res_kind   = q_item.is_quote ? KIND_STR : KIND_EXPR;
                        res_unterm = 1'b1;
                    end
                    else if (!(q_item.is_slash && !q_item.last))
                    begin
                        res_emit = 1'b1;
                    end
                end
            end
        endcase
    end

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        close_next  = close_reg;
        open_next   = open_reg;
        depth_next  = depth_reg;
        iquote_next = iquote_reg;
        esc_next    = esc_reg;
        star_next   = star_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        if (step)
        begin
            unique case (mode_reg)
                MODE_STR:
                begin
                    count_next = cnt_inc;
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (q_item.is_bslash)
                    begin
                        esc_next = 1'b1;
                    end
                end
                MODE_EXPR:
                begin
                    count_next = cnt_inc;
                    ovf_next   = ovf_upd;
                    if (in_quote)
                    begin
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                        end
                        else if (q_item.is_bslash)
                        begin
                            esc_next = 1'b1;
                        end
                        else if (q_item.ch == iquote_reg)
                        begin
                            iquote_next = CH_NUL;
                        end
                    end
                    else if (hit_close)
                    begin
                        if (depth_reg != 8'd0)
                        begin
                            depth_next = depth_reg - 8'd1;
                        end
                    end
                    else if (hit_open)
                    begin
                        if (depth_reg < MAX_DEPTH)
                        begin
                            depth_next = depth_reg + 8'd1;
                        end
                    end
                    else if (q_item.is_quote)
                    begin
                        iquote_next = q_item.ch;
                        esc_next    = 1'b0;
                    end
                end
                MODE_LINE:
                begin
                    count_next = cnt_inc;
                end
                MODE_BLOCK:
                begin
                    count_next = cnt_inc;
                    star_next  = q_item.is_star;
                end
                MODE_SLASH:
                begin
                    count_next = cnt_inc;
                    if (q_item.is_slash)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (q_item.is_star)
                    begin
                        mode_next = MODE_BLOCK;
                        star_next = 1'b0;
                    end
                end
                default:
                begin
                    mode_next   = MODE_IDLE;
                    close_next  = CH_NUL;
                    open_next   = CH_NUL;
                    depth_next  = 8'd0;
                    iquote_next = CH_NUL;
                    esc_next    = 1'b0;
                    star_next   = 1'b0;
                    count_next  = 16'd0;
                    ovf_next    = 1'b0;
                    if (q_item.start)
                    begin
                        if (q_item.is_quote)
                        begin
                            mode_next  = MODE_STR;
                            close_next = q_item.ch;
                            count_next = LEN_ONE;
                        end
                        else if (q_item.is_open)
                        begin
                            mode_next  = MODE_EXPR;
                            open_next  = q_item.ch;
                            close_next = q_item.closer;
                            count_next = LEN_ONE;
                        end
                        else if (q_item.is_slash && !q_item.last)
                        begin
                            mode_next  = MODE_SLASH;
                            count_next = LEN_ONE;
                        end
                    end
                end
            endcase
            // any result returns the scanner to a clean idle
            if (res_emit)
            begin
                mode_next   = MODE_IDLE;
                close_next  = CH_NUL;
                open_next   = CH_NUL;
                depth_next  = 8'd0;
                iquote_next = CH_NUL;
                esc_next    = 1'b0;
                star_next   = 1'b0;
                count_next  = 16'd0;
                ovf_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            close_reg     <= CH_NUL;
            open_reg      <= CH_NUL;
            depth_reg     <= 8'd0;
            iquote_reg    <= CH_NUL;
            esc_reg       <= 1'b0;
            star_reg      <= 1'b0;
            count_reg     <= 16'd0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            close_reg  <= close_next;
            open_reg   <= open_next;
            depth_reg  <= depth_next;
            iquote_reg <= iquote_next;
            esc_reg    <= esc_next;
            star_reg   <= star_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            if (step && res_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_emit)
        begin
            out_len_reg    <= res_len;
            out_kind_reg   <= res_kind;
            out_unterm_reg <= res_unterm;
            out_ovf_reg    <= res_ovf;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frag_len       = out_len_reg;
    assign kind           = out_kind_reg;
    assign unterminated   = out_unterm_reg;
    assign depth_overflow = out_ovf_reg;

`ifndef SYNTH
    a_depth_only_in_expr: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_EXPR) |-> (depth_reg == 8'd0))
        else $error("nest depth left nonzero outside an expression");
    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (count_reg == 16'd0 && !ovf_reg))
        else $error("idle scanner holds stale count");
    a_unknown_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_UNKNOWN) |-> (out_len_reg == 16'd0))
        else $error("unknown fragment with nonzero length");
`endif

endmodule

### hw/rtl/delimited_fragment_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_fragment_scanner
// Finds the length of a quoted string, bracket expression or comment that a
// flagged opener byte starts. Takes one byte per cycle unless stalled.
// A front stage classifies each byte into a 4-entry queue; the scanner
// retires one queued byte per cycle, unless a held result is stalled, into a
// result register, so the sustained rate is one byte per clock. A final byte
// passes through the queue and its result then through the result register.
// The input stalls only when the queue is full, which happens only while the
// output side is stalled. Nesting depth saturates at 255, length at 65535.
// ----------------------------------------------------------------------------
module delimited_fragment_scanner
    import dfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        start_req,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] frag_len,
    output logic [2:0]  kind,
    output logic        unterminated,
    output logic        depth_overflow
);

    logic      push;
    dfs_item_t push_item;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    dfs_item_t q_item;

    dfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .start_req (start_req),
        .last      (last),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    dfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    dfs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frag_len       (frag_len),
        .kind           (kind),
        .unterminated   (unterminated),
        .depth_overflow (depth_overflow)
    );

endmodule
